// ----- sv/asvm_pkg.sv -----
// Shared constants for the accumulator/stack execute block.
// Opcodes, status codes and program counter geometry. No dependencies.
`default_nettype none
package asvm_pkg;
  localparam int unsigned ProgramWords = 1024;
  localparam int unsigned PcBits       = $clog2(ProgramWords);

  localparam logic [7:0] OP_LOAD  = 8'h01;
  localparam logic [7:0] OP_ADD   = 8'h02;
  localparam logic [7:0] OP_DIV   = 8'h03;
  localparam logic [7:0] OP_MUL   = 8'h04;
  localparam logic [7:0] OP_SUB   = 8'h05;
  localparam logic [7:0] OP_JMP   = 8'h06;
  localparam logic [7:0] OP_CALL  = 8'h07;
  localparam logic [7:0] OP_JZ    = 8'h08;
  localparam logic [7:0] OP_PUSH  = 8'h0A;
  localparam logic [7:0] OP_POP   = 8'h0B;
  localparam logic [7:0] OP_RET   = 8'h0E;
  localparam logic [7:0] OP_LOADS = 8'h10;
  localparam logic [7:0] OP_CALLG = 8'h11;
  localparam logic [7:0] OP_CALLL = 8'h12;
  localparam logic [7:0] OP_CALLE = 8'h13;
  localparam logic [7:0] OP_CALLN = 8'h14;
  localparam logic [7:0] OP_HLTE  = 8'h15;
  localparam logic [7:0] OP_HLTN  = 8'h16;
  localparam logic [7:0] OP_HLTG  = 8'h17;
  localparam logic [7:0] OP_HLTL  = 8'h18;
  localparam logic [7:0] OP_DEC   = 8'h19;
  localparam logic [7:0] OP_HALT  = 8'hFF;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_UNDER = 3'd3;
  localparam logic [2:0] ST_INDEX = 3'd4;
  localparam logic [2:0] ST_DIVZ  = 3'd5;

  typedef logic [63:0] word_t;
endpackage
`default_nettype wire

// ----- sv/asvm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module asvm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire                     rd_en,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ----- sv/asvm_mul.sv -----
// Iterative 64x64 multiplier, low 64 bits, one 32x32 product per cycle.
// Depends on asvm_pkg.
`default_nettype none
module asvm_mul (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  input  asvm_pkg::word_t op_a,
  input  asvm_pkg::word_t op_b,
  output logic           done,
  output asvm_pkg::word_t product
);
  import asvm_pkg::*;

  logic [1:0]  step;
  logic        busy;
  word_t       a_q;
  word_t       b_q;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] pp;

  always_comb begin
    case (step)
      2'd0:    begin mx = a_q[31:0];  my = b_q[31:0];  end
      2'd1:    begin mx = a_q[31:0];  my = b_q[63:32]; end
      default: begin mx = a_q[63:32]; my = b_q[31:0];  end
    endcase
    pp = mx * my;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= 2'd0;
      a_q  <= op_a;
      b_q  <= op_b;
    end else if (busy) begin
      if (step == 2'd0) begin
        product <= pp;
      end else begin
        product[63:32] <= product[63:32] + pp[31:0];
      end
      if (step == 2'd2) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      step <= step + 2'd1;
    end
  end
endmodule
`default_nettype wire

// ----- sv/asvm_div.sv -----
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating.
// Depends on asvm_pkg. Divisor must be nonzero and not minus one.
`default_nettype none
module asvm_div (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  input  asvm_pkg::word_t dividend,
  input  asvm_pkg::word_t divisor,
  output logic           done,
  output asvm_pkg::word_t quotient
);
  import asvm_pkg::*;

  logic [6:0]  cnt;
  logic        busy;
  logic        neg;
  logic [64:0] rem;
  word_t       quo;
  word_t       den;
  logic [64:0] rem_sh;
  logic [64:0] diff;

  assign rem_sh   = {rem[63:0], quo[63]};
  assign diff     = rem_sh - {1'b0, den};
  assign quotient = neg ? (64'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 7'd0;
      neg  <= dividend[63] ^ divisor[63];
      rem  <= 65'd0;
      quo  <= dividend[63] ? (64'd0 - dividend) : dividend;
      den  <= divisor[63] ? (64'd0 - divisor) : divisor;
    end else if (busy) begin
      if (!diff[64]) begin
        rem <= diff;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[62:0], 1'b0};
      end
      if (cnt == 7'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      cnt <= cnt + 7'd1;
    end
  end
endmodule
`default_nettype wire

// ----- sv/accumulator_stack_vm_execute.sv -----
// Accumulator/stack machine execute block: one instruction word in, one state word out.
// Usage: present opcode and two operands on the input channel (valid/ready); each word
// yields exactly one output word with next_pc, accumulator, stack depth and status.
// After reset the stack RAM is swept to zero, one entry per cycle, with in_ready low.
// Then in_ready is high whenever no instruction is in flight.
// For most instructions the stack RAM read happens at the accepting edge; the instruction
// then executes and writes back in S_EXEC once the output register is free. MUL takes
// three 32x32 partial products on one multiplier; DIV takes one quotient bit per cycle.
// A new instruction is accepted only in S_IDLE, after the previous one has committed.
// An input word may be accepted while the previous output word still waits. If the
// receiver stalls, execution holds with the finished word in the output register.
// Once status is nonzero the state is frozen and every word returns it unchanged,
// until reset.
`default_nettype none
module accumulator_stack_vm_execute #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [7:0]                         opcode,
  input  wire signed [63:0]                 operand_a,
  input  wire signed [63:0]                 operand_b,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [asvm_pkg::PcBits-1:0]       next_pc,
  output logic signed [63:0]                acc_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]  stack_depth,
  output logic [2:0]                        status
);
  import asvm_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [AW-1:0]     clr_addr;
  logic [PcBits-1:0] pc;
  logic [PcBits-1:0] pc_next;
  word_t             acc;
  word_t             acc_next;
  logic [DW-1:0]     depth;
  logic [DW-1:0]     depth_next;
  logic [2:0]        run;
  logic [2:0]        run_next;
  logic [7:0]        op_q;
  word_t             a_q;
  word_t             b_q;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  word_t             rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  word_t             wr_data;
  logic              push_en;
  word_t             push_data;

  logic              mul_start;
  logic              mul_done;
  word_t             mul_res;
  logic              div_start;
  logic              div_done;
  word_t             div_res;

  logic              out_free;
  logic              commit;
  logic [PcBits-1:0] pc4;
  logic              full;
  logic              lt_acc_b;
  logic              gt_acc_b;
  logic              lt_acc_a;
  logic              gt_acc_a;
  logic              call_en;
  logic              bad_index;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign rd_en    = in_valid && in_ready;

  always_comb begin
    if (opcode == OP_LOADS) begin
      rd_addr = operand_a[AW-1:0];
    end else begin
      rd_addr = AW'(depth - DW'(1));
    end
  end

  asvm_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  asvm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (acc),
    .op_b    (a_q),
    .done    (mul_done),
    .product (mul_res)
  );

  asvm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (a_q),
    .done     (div_done),
    .quotient (div_res)
  );

  assign pc4       = pc + PcBits'(4);
  assign full      = (depth >= DW'(STACK_DEPTH));
  assign lt_acc_b  = $signed(acc) < $signed(b_q);
  assign gt_acc_b  = $signed(acc) > $signed(b_q);
  assign lt_acc_a  = $signed(acc) < $signed(a_q);
  assign gt_acc_a  = $signed(acc) > $signed(a_q);
  assign bad_index = a_q[63] || (a_q[62:0] >= 63'(STACK_DEPTH));

  always_comb begin
    case (op_q)
      OP_CALL:  call_en = 1'b1;
      OP_CALLG: call_en = gt_acc_b;
      OP_CALLL: call_en = lt_acc_b;
      OP_CALLE: call_en = (acc == b_q);
      OP_CALLN: call_en = (acc != b_q);
      default:  call_en = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    acc_next   = acc;
    depth_next = depth;
    run_next   = run;
    push_en    = 1'b0;
    push_data  = acc;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(STACK_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (run != ST_RUN) begin
          if (out_free) begin
            commit     = 1'b1;
            state_next = S_IDLE;
          end
        end else if (op_q == OP_MUL) begin
          mul_start  = 1'b1;
          state_next = S_MUL;
        end else if (op_q == OP_DIV && a_q != 64'd0 && a_q != '1) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else if (out_free) begin
          commit     = 1'b1;
          state_next = S_IDLE;
          pc_next    = pc4;
          case (op_q)
            OP_LOAD: acc_next = a_q;
            OP_ADD:  acc_next = acc + a_q;
            OP_SUB:  acc_next = acc - a_q;
            OP_DEC:  acc_next = acc - 64'd1;
            OP_DIV: begin
              if (a_q == 64'd0) begin
                run_next = ST_DIVZ;
              end else begin
                acc_next = 64'd0 - acc;
              end
            end
            OP_JMP: pc_next = a_q[PcBits-1:0];
            OP_JZ: begin
              if (acc == 64'd0) begin
                pc_next = a_q[PcBits-1:0];
              end
            end
            OP_PUSH: begin
              if (full) begin
                run_next = ST_OVER;
              end else begin
                push_en    = 1'b1;
                depth_next = depth + DW'(1);
              end
            end
            OP_POP: begin
              if (depth == '0) begin
                run_next = ST_UNDER;
              end else begin
                depth_next = depth - DW'(1);
                acc_next   = rd_data;
              end
            end
            OP_RET: begin
              if (depth == '0) begin
                run_next = ST_UNDER;
              end else begin
                depth_next = depth - DW'(1);
                pc_next    = rd_data[PcBits-1:0];
              end
            end
            OP_LOADS: begin
              if (bad_index) begin
                run_next = ST_INDEX;
              end else begin
                acc_next = rd_data;
              end
            end
            OP_CALL, OP_CALLG, OP_CALLL, OP_CALLE, OP_CALLN: begin
              if (call_en) begin
                if (full) begin
                  run_next = ST_OVER;
                end else begin
                  push_en    = 1'b1;
                  push_data  = 64'(pc4);
                  depth_next = depth + DW'(1);
                  pc_next    = a_q[PcBits-1:0];
                end
              end
            end
            OP_HLTE: if (acc == a_q) run_next = ST_HALT;
            OP_HLTN: if (acc != a_q) run_next = ST_HALT;
            OP_HLTG: if (gt_acc_a)   run_next = ST_HALT;
            OP_HLTL: if (lt_acc_a)   run_next = ST_HALT;
            OP_HALT: run_next = ST_HALT;
            default: ;
          endcase
        end
      end
      S_MUL: begin
        if (mul_done && out_free) begin
          commit     = 1'b1;
          state_next = S_IDLE;
          pc_next    = pc4;
          acc_next   = mul_res;
        end
      end
      S_DIV: begin
        if (div_done && out_free) begin
          commit     = 1'b1;
          state_next = S_IDLE;
          pc_next    = pc4;
          acc_next   = div_res;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = 64'd0;
    end else begin
      wr_en   = push_en;
      wr_addr = depth[AW-1:0];
      wr_data = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pc        <= '0;
      acc       <= 64'd0;
      depth     <= '0;
      run       <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (rd_en) begin
        op_q <= opcode;
        a_q  <= operand_a;
        b_q  <= operand_b;
      end
      if (commit) begin
        pc          <= pc_next;
        acc         <= acc_next;
        depth       <= depth_next;
        run         <= run_next;
        out_valid   <= 1'b1;
        next_pc     <= pc_next;
        acc_value   <= acc_next;
        stack_depth <= depth_next;
        status      <= run_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
